// ===== sv/rarl_pkg.sv =====
// Shared types, constants and helper functions for the robust anchor residual loss block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package rarl_pkg;

   localparam logic [2:0] MAC_HOLD  = 3'd0;
   localparam logic [2:0] MAC_MUL   = 3'd1;
   localparam logic [2:0] MAC_ADD   = 3'd2;
   localparam logic [2:0] MAC_SUB   = 3'd3;
   localparam logic [2:0] MAC_SHADD = 3'd4;

   localparam int MAC_SHIFT = 25;

   localparam logic [2:0] CSR_ENABLE = 3'd0;
   localparam logic [2:0] CSR_DELTA  = 3'd1;
   localparam logic [2:0] CSR_WEIGHT = 3'd2;
   localparam logic [2:0] CSR_ROBOT_X = 3'd3;
   localparam logic [2:0] CSR_ROBOT_Y = 3'd4;
   localparam logic [2:0] CSR_ROBOT_YAW = 3'd5;

   localparam logic signed [17:0] PI_Q12      = 18'sd12868;
   localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;
   localparam logic signed [17:0] HALF_PI_Q12 = 18'sd6434;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [37:0] a;
      logic signed [25:0] b;
   } mac_ctl_type;

   typedef struct packed {
      logic        start;
      logic        div_mode;
      logic [60:0] radicand;
      logic [19:0] numer;
      logic [31:0] divisor;
   } rd_ctl_type;

   function automatic logic [16:0] atan_entry(input logic [3:0] i);
      logic [16:0] r;
      case (i)
         4'd0:  r = 17'd51472;
         4'd1:  r = 17'd30386;
         4'd2:  r = 17'd16055;
         4'd3:  r = 17'd8150;
         4'd4:  r = 17'd4091;
         4'd5:  r = 17'd2047;
         4'd6:  r = 17'd1024;
         4'd7:  r = 17'd512;
         4'd8:  r = 17'd256;
         4'd9:  r = 17'd128;
         4'd10: r = 17'd64;
         4'd11: r = 17'd32;
         4'd12: r = 17'd16;
         4'd13: r = 17'd8;
         4'd14: r = 17'd4;
         4'd15: r = 17'd2;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [17:0] wrap18(input logic signed [17:0] a);
      logic signed [17:0] r;
      r = a;
      for (int k = 0; k < 4; k++) begin
         if (r > PI_Q12) r = r - TWO_PI_Q12;
      end
      for (int k = 0; k < 4; k++) begin
         if (r <= -PI_Q12) r = r + TWO_PI_Q12;
      end
      return r;
   endfunction

   function automatic logic signed [63:0] round_sh(input logic signed [63:0] v, input int n);
      logic signed [63:0] half;
      logic signed [63:0] mag;
      half = 64'sd1 <<< (n - 1);
      mag  = -v;
      if (!v[63]) return (v + half) >>> n;
      return -((mag + half) >>> n);
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

endpackage

// ===== sv/rarl_mac.sv =====
// Shared signed multiply-accumulate unit driven by the sequencer each cycle.
// Depends on rarl_pkg for the operation codes and the control struct.
`timescale 1ns / 1ps
module rarl_mac import rarl_pkg::*; (
   input  logic               clock,
   input  mac_ctl_type        ctl,
   output logic signed [63:0] acc
);

   logic signed [63:0] acc_ff;
   logic signed [63:0] acc_in;
   logic signed [63:0] prod;

   assign prod = 64'(ctl.a) * 64'(ctl.b);

   always_comb begin
      case (ctl.op)
         MAC_MUL:   acc_in = prod;
         MAC_ADD:   acc_in = acc_ff + prod;
         MAC_SUB:   acc_in = acc_ff - prod;
         MAC_SHADD: acc_in = (acc_ff >>> MAC_SHIFT) + prod;
         default:   acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== sv/rarl_cordic.sv =====
// Iterative 16-step CORDIC that turns the robot heading into cosine and sine in Q2.16.
// Depends on rarl_pkg for the arctangent table, angle wrap and rounding.
`timescale 1ns / 1ps
module rarl_cordic import rarl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] yaw,
   output logic               done,
   output logic signed [17:0] cos_q,
   output logic signed [17:0] sin_q
);

   logic               busy_ff, busy_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic [3:0]         iter_ff, iter_in;
   logic signed [32:0] x_ff, x_in, y_ff, y_in;
   logic signed [19:0] z_ff, z_in;
   logic               neg_ff, neg_in;
   logic signed [17:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [17:0] ang;
   logic signed [17:0] fold;
   logic signed [32:0] dx, dy;
   logic signed [19:0] at;
   logic signed [63:0] cr, sr;

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      ang     = wrap18(18'(yaw));
      fold    = ang;
      dx      = y_ff >>> iter_ff;
      dy      = x_ff >>> iter_ff;
      at      = 20'(signed'({1'b0, atan_entry(iter_ff)}));
      cr      = round_sh(64'(x_ff), 14);
      sr      = round_sh(64'(y_ff), 14);
      if (start) begin
         neg_in = 1'b0;
         if (ang > HALF_PI_Q12) begin
            fold   = PI_Q12 - ang;
            neg_in = 1'b1;
         end else if (ang < -HALF_PI_Q12) begin
            fold   = -PI_Q12 - ang;
            neg_in = 1'b1;
         end
         z_in    = 20'(fold) <<< 4;
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[19]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         iter_in = iter_ff + 4'd1;
         if (iter_ff == 4'd15) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         cos_in  = neg_ff ? -cr[17:0] : cr[17:0];
         sin_in  = sr[17:0];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      neg_ff  <= neg_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign done  = done_ff;
   assign cos_q = cos_ff;
   assign sin_q = sin_ff;

endmodule

// ===== sv/rarl_rootdiv.sv =====
// Bit-serial unit for the integer square root of the distance and the Huber weight division.
// Depends on rarl_pkg for the control struct.
`timescale 1ns / 1ps
module rarl_rootdiv import rarl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  rd_ctl_type  ctl,
   output logic        done,
   output logic [31:0] result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        mode_ff, mode_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] v_ff, v_in, res_ff, res_in;
   logic [31:0] div_ff, div_in;
   logic [63:0] bitv, trial;
   logic [32:0] rem2;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      div_in  = div_ff;
      bitv    = 64'd1 << (7'd62 - {1'b0, cnt_ff, 1'b0});
      trial   = res_ff + bitv;
      rem2    = {v_ff[31:0], 1'b0};
      if (ctl.start) begin
         busy_in = 1'b1;
         mode_in = ctl.div_mode;
         cnt_in  = '0;
         res_in  = '0;
         div_in  = ctl.divisor;
         v_in    = ctl.div_mode ? 64'(ctl.numer) : 64'(ctl.radicand);
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 5'd1;
         if (mode_ff) begin
            if (rem2 >= {1'b0, div_ff}) begin
               v_in   = 64'(rem2 - {1'b0, div_ff});
               res_in = {res_ff[62:0], 1'b1};
            end else begin
               v_in   = 64'(rem2);
               res_in = {res_ff[62:0], 1'b0};
            end
            if (cnt_ff == 5'd7) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            if (v_ff >= trial) begin
               v_in   = v_ff - trial;
               res_in = (res_ff >> 1) + bitv;
            end else begin
               res_in = res_ff >> 1;
            end
            if (cnt_ff == 5'd31) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      v_ff    <= v_in;
      res_ff  <= res_in;
      div_ff  <= div_in;
   end

   assign done   = done_ff;
   assign result = res_ff[31:0];

endmodule

// ===== sv/robust_anchor_residual_loss_core.sv =====
// Robust anchor residual loss: sequencer, registers and output stage over the shared units.
// Depends on rarl_pkg, rarl_mac, rarl_cordic and rarl_rootdiv.
// From accept, the CORDIC, geometry, square root and weighting phases run in turn; a Huber
// division runs before weighting when the root exceeds delta; a disabled item skips them all.
// One item at a time; the next is accepted in the cycle after the result beat is taken.
// Synchronous reset sets the control state, the accumulator and the CSR settings to defaults.
`timescale 1ns / 1ps
module robust_anchor_residual_loss_core import rarl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // world_x, world_y, world_yaw, seen_x, seen_y, seen_yaw, info_diag, info_offdiag
   input  logic [279:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // loss_total
   output logic [47:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TRIG = 3'd1;
   localparam logic [2:0] ST_GEO  = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_TERM = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [4:0]         step_ff, step_in;
   logic               enable_ff, enable_in;
   logic [15:0]        delta_ff, delta_in, weight_ff, weight_in;
   logic signed [31:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [15:0] ryaw_ff, ryaw_in;
   logic signed [32:0] dwx_ff, dwx_in, dwy_ff, dwy_in;
   logic signed [31:0] seen_x_ff, seen_x_in, seen_y_ff, seen_y_in;
   logic signed [23:0] rq0_ff, rq0_in, rq1_ff, rq1_in, rq2_ff, rq2_in;
   logic signed [19:0] l00_ff, l00_in, l11_ff, l11_in, l22_ff, l22_in;
   logic signed [19:0] l01_ff, l01_in, l02_ff, l02_in, l12_ff, l12_in;
   logic signed [37:0] v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in;
   logic [60:0]        um2_ff, um2_in;
   logic [8:0]         w_ff, w_in;
   logic [24:0]        a_ff, a_in;
   logic               last_ff, last_in;
   logic [47:0]        accum_ff, accum_in, total_ff, total_in;

   mac_ctl_type        mac_ctl;
   rd_ctl_type         rd_ctl;
   logic signed [63:0] mac_acc;
   logic               cordic_start, cordic_done;
   logic signed [17:0] cos_q, sin_q;
   logic               rd_done;
   logic [31:0]        rd_result;

   logic               fin_go, fin_last;
   logic [47:0]        fin_term, term_sat;
   logic [48:0]        sum49;
   logic [47:0]        sum_sat;
   logic [19:0]        delta12;
   logic signed [31:0] seen_sel;
   logic signed [63:0] px_full, res_diff;
   logic signed [23:0] rq_new;
   logic signed [63:0] v_full;
   logic signed [17:0] ryaw_sum;

   rarl_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .acc   (mac_acc)
   );

   rarl_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .yaw   (ryaw_ff),
      .done  (cordic_done),
      .cos_q (cos_q),
      .sin_q (sin_q)
   );

   rarl_rootdiv u_rootdiv (
      .clock  (clock),
      .reset  (reset),
      .ctl    (rd_ctl),
      .done   (rd_done),
      .result (rd_result)
   );

   assign delta12  = {delta_ff, 4'b0000};
   assign seen_sel = (step_ff == 5'd2) ? seen_x_ff : seen_y_ff;
   assign px_full  = round_sh(mac_acc, 16);
   assign res_diff = 64'(seen_sel) - px_full;
   assign rq_new   = sat24(round_sh(res_diff, 4));
   assign v_full   = round_sh(mac_acc, 8);
   assign term_sat = (mac_acc > signed'({16'd0, MAX48})) ? MAX48 : mac_acc[47:0];
   assign sum49    = {1'b0, accum_ff} + {1'b0, fin_term};
   assign sum_sat  = sum49[48] ? MAX48 : sum49[47:0];
   assign fin_last = (state_ff == ST_IDLE) ? req_tlast : last_ff;
   assign ryaw_sum = 18'(signed'(req_tdata[159:144])) - 18'(signed'(req_tdata[79:64]))
                     + 18'(ryaw_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      enable_in    = enable_ff;
      delta_in     = delta_ff;
      weight_in    = weight_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      ryaw_in      = ryaw_ff;
      dwx_in       = dwx_ff;
      dwy_in       = dwy_ff;
      seen_x_in    = seen_x_ff;
      seen_y_in    = seen_y_ff;
      rq0_in       = rq0_ff;
      rq1_in       = rq1_ff;
      rq2_in       = rq2_ff;
      l00_in       = l00_ff;
      l11_in       = l11_ff;
      l22_in       = l22_ff;
      l01_in       = l01_ff;
      l02_in       = l02_ff;
      l12_in       = l12_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      um2_in       = um2_ff;
      w_in         = w_ff;
      a_in         = a_ff;
      last_in      = last_ff;
      accum_in     = accum_ff;
      total_in     = total_ff;
      mac_ctl      = '{op: MAC_HOLD, a: '0, b: '0};
      rd_ctl       = '0;
      cordic_start = 1'b0;
      fin_go       = 1'b0;
      fin_term     = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:    enable_in = csr_wdata[0];
            CSR_DELTA:     delta_in  = csr_wdata[15:0];
            CSR_WEIGHT:    weight_in = csr_wdata[15:0];
            CSR_ROBOT_X:   rx_in     = csr_wdata;
            CSR_ROBOT_Y:   ry_in     = csr_wdata;
            CSR_ROBOT_YAW: ryaw_in   = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dwx_in    = 33'(signed'(req_tdata[31:0])) - 33'(rx_ff);
               dwy_in    = 33'(signed'(req_tdata[63:32])) - 33'(ry_ff);
               seen_x_in = req_tdata[111:80];
               seen_y_in = req_tdata[143:112];
               rq2_in    = 24'(wrap18(ryaw_sum));
               l00_in    = req_tdata[179:160];
               l11_in    = req_tdata[199:180];
               l22_in    = req_tdata[219:200];
               l01_in    = req_tdata[239:220];
               l02_in    = req_tdata[259:240];
               l12_in    = req_tdata[279:260];
               last_in   = req_tlast;
               if (enable_ff) begin
                  cordic_start = 1'b1;
                  state_in     = ST_TRIG;
               end else begin
                  fin_go = 1'b1;
               end
            end
         end
         ST_TRIG: begin
            if (cordic_done) begin
               state_in = ST_GEO;
               step_in  = '0;
            end
         end
         ST_GEO: begin
            step_in = step_ff + 5'd1;
            case (step_ff)
               5'd0:  mac_ctl = '{op: MAC_MUL, a: 38'(dwx_ff), b: 26'(cos_q)};
               5'd1:  mac_ctl = '{op: MAC_ADD, a: 38'(dwy_ff), b: 26'(sin_q)};
               5'd2: begin
                  rq0_in  = rq_new;
                  mac_ctl = '{op: MAC_MUL, a: 38'(dwy_ff), b: 26'(cos_q)};
               end
               5'd3:  mac_ctl = '{op: MAC_SUB, a: 38'(dwx_ff), b: 26'(sin_q)};
               5'd4: begin
                  rq1_in  = rq_new;
                  mac_ctl = '{op: MAC_MUL, a: 38'(rq0_ff), b: 26'(l00_ff)};
               end
               5'd5:  mac_ctl = '{op: MAC_ADD, a: 38'(rq1_ff), b: 26'(l01_ff)};
               5'd6:  mac_ctl = '{op: MAC_ADD, a: 38'(rq2_ff), b: 26'(l02_ff)};
               5'd7: begin
                  v0_in   = v_full[37:0];
                  mac_ctl = '{op: MAC_MUL, a: 38'(rq0_ff), b: 26'(l01_ff)};
               end
               5'd8:  mac_ctl = '{op: MAC_ADD, a: 38'(rq1_ff), b: 26'(l11_ff)};
               5'd9:  mac_ctl = '{op: MAC_ADD, a: 38'(rq2_ff), b: 26'(l12_ff)};
               5'd10: begin
                  v1_in   = v_full[37:0];
                  mac_ctl = '{op: MAC_MUL, a: 38'(rq0_ff), b: 26'(l02_ff)};
               end
               5'd11: mac_ctl = '{op: MAC_ADD, a: 38'(rq1_ff), b: 26'(l12_ff)};
               5'd12: mac_ctl = '{op: MAC_ADD, a: 38'(rq2_ff), b: 26'(l22_ff)};
               5'd13: begin
                  v2_in   = v_full[37:0];
                  mac_ctl = '{op: MAC_MUL, a: v0_ff, b: 26'(rq0_ff)};
               end
               5'd14: mac_ctl = '{op: MAC_ADD, a: v1_ff, b: 26'(rq1_ff)};
               5'd15: mac_ctl = '{op: MAC_ADD, a: v2_ff, b: 26'(rq2_ff)};
               5'd16: begin
                  um2_in          = mac_acc[63] ? '0 : mac_acc[60:0];
                  rd_ctl.start    = 1'b1;
                  rd_ctl.div_mode = 1'b0;
                  rd_ctl.radicand = mac_acc[63] ? '0 : mac_acc[60:0];
                  state_in        = ST_ROOT;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ROOT: begin
            if (rd_done) begin
               if (rd_result <= 32'(delta12)) begin
                  w_in     = 9'd256;
                  state_in = ST_TERM;
                  step_in  = '0;
               end else begin
                  rd_ctl.start    = 1'b1;
                  rd_ctl.div_mode = 1'b1;
                  rd_ctl.numer    = delta12;
                  rd_ctl.divisor  = rd_result;
                  state_in        = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (rd_done) begin
               w_in     = rd_result[8:0];
               state_in = ST_TERM;
               step_in  = '0;
            end
         end
         ST_TERM: begin
            step_in = step_ff + 5'd1;
            case (step_ff)
               5'd0: mac_ctl = '{op: MAC_MUL, a: 38'(w_ff), b: 26'(weight_ff)};
               5'd1: begin
                  a_in    = mac_acc[24:0];
                  mac_ctl = '{op: MAC_MUL, a: 38'(um2_ff[24:0]), b: 26'(mac_acc[24:0])};
               end
               5'd2: mac_ctl = '{op: MAC_SHADD, a: 38'(um2_ff[60:25]), b: 26'(a_ff)};
               5'd3: begin
                  fin_go   = 1'b1;
                  fin_term = term_sat;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (fin_go) begin
         total_in = sum_sat;
         accum_in = fin_last ? '0 : sum_sat;
         state_in = ST_OUT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         enable_ff <= 1'b1;
         delta_ff  <= 16'd256;
         weight_ff <= 16'd256;
         rx_ff     <= '0;
         ry_ff     <= '0;
         ryaw_ff   <= '0;
         accum_ff  <= '0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         enable_ff <= enable_in;
         delta_ff  <= delta_in;
         weight_ff <= weight_in;
         rx_ff     <= rx_in;
         ry_ff     <= ry_in;
         ryaw_ff   <= ryaw_in;
         accum_ff  <= accum_in;
         last_ff   <= last_in;
      end
      dwx_ff    <= dwx_in;
      dwy_ff    <= dwy_in;
      seen_x_ff <= seen_x_in;
      seen_y_ff <= seen_y_in;
      rq0_ff    <= rq0_in;
      rq1_ff    <= rq1_in;
      rq2_ff    <= rq2_in;
      l00_ff    <= l00_in;
      l11_ff    <= l11_in;
      l22_ff    <= l22_in;
      l01_ff    <= l01_in;
      l02_ff    <= l02_in;
      l12_ff    <= l12_in;
      v0_ff     <= v0_in;
      v1_ff     <= v1_in;
      v2_ff     <= v2_in;
      um2_ff    <= um2_in;
      w_ff      <= w_in;
      a_ff      <= a_in;
      total_ff  <= total_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = total_ff;
   assign rsp_tlast  = last_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result sides active together");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (accum_ff == '0))
      else $error("accumulator not cleared after final beat");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEO) |-> (step_ff <= 5'd16))
      else $error("geometry step counter out of range");

   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (accum_ff == rsp_tdata))
      else $error("accumulator and result beat disagree");

endmodule
